// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked property, held off while reset is high
`define ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed in %m");
// checked property, live during reset too
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed in %m");
`else
`define ASSERT_RST(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- rtl/core/olie_pkg.sv -----
// shared types and codes of the ordered list engine
package olie_pkg;

  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 8;
  localparam int ELEM_W   = 32;
  localparam int COUNT_W  = 5;

  localparam logic [OP_W-1:0] OP_READ_AT    = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND     = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_INSERT     = 3'd3;
  localparam logic [OP_W-1:0] OP_ERASE      = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;
  localparam logic [OP_W-1:0] OP_READ_FRONT = 3'd6;
  localparam logic [OP_W-1:0] OP_READ_BACK  = 3'd7;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // broadcast to every cell, qualified by the shared index
  typedef struct packed {
    logic ins;  // cells at the index take the new word, cells above shift right
    logic del;  // cells at or above the index take their right neighbor
    logic rd;   // cell at the index drives its word onto the read bus
  } cell_ctrl_t;

endpackage

// ----- rtl/core/olie_cell.sv -----
// one storage cell of the ordered list shift chain
module olie_cell
  import olie_pkg::*;
#(
  parameter int INDEX      = 0,
  parameter int IDX_W      = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic [IDX_W-1:0]      idx,
  input  logic [DATA_WIDTH-1:0] elem,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] rd_data
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic at_me;
  logic above;

  assign at_me = (idx == MY_IDX);
  assign above = (idx < MY_IDX);

  always_ff @(posedge clk) begin
    if (ctrl.ins && at_me) begin
      data <= elem;
    end else if (ctrl.ins && above) begin
      data <= left_data;
    end else if (ctrl.del && (at_me || above)) begin
      data <= right_data;
    end
  end

  assign rd_data = (ctrl.rd && at_me) ? data : '0;

endmodule

// ----- rtl/core/ordered_list_insert_erase_engine_unit.sv -----
// top level of the ordered list engine: decoder, length count, cell chain, result register
// a result is registered and appears in the cycle after its transaction is accepted
// throughput: one transaction per cycle while the result side keeps taking results
// the whole update (shift, insert, erase) happens in one step across the cell chain
// reset clears the length count and the result valid; cell contents are not cleared
// and are never read beyond the current length
`include "assert_macros.svh"

module ordered_list_insert_erase_engine_unit
  import olie_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  // request channel
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [OP_W-1:0]     operation,
  input  logic [POS_W-1:0]    position,
  input  logic [ELEM_W-1:0]   element,
  // result channel
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [ELEM_W-1:0]   read_data,
  output logic                read_valid,
  output logic [STATUS_W-1:0] status,
  output logic [COUNT_W-1:0]  count,
  output logic                is_empty
);

  // width of the length count and of the index broadcast to the cells
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // length of the list
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] fill_next;

  // handshake: a result register parts the two sides
  logic req_accept;
  assign req_stall  = rsp_valid && rsp_stall;
  assign req_accept = req_valid && !req_stall;

  // word to store, cut or padded to the cell width
  logic [DATA_WIDTH+ELEM_W-1:0] elem_ext;
  logic [DATA_WIDTH-1:0]        elem;
  assign elem_ext = {{DATA_WIDTH{1'b0}}, element};
  assign elem     = elem_ext[DATA_WIDTH-1:0];

  logic [IDX_W-1:0] pos_w;
  logic [IDX_W-1:0] fill_w;
  logic             full;
  logic             empty;
  assign pos_w  = IDX_W'(position);
  assign fill_w = IDX_W'(fill_count);
  assign full   = (fill_count == FULL_CNT);
  assign empty  = (fill_count == '0);

  // operation decoder
  cell_ctrl_t          ctrl_raw;
  cell_ctrl_t          ctrl;
  logic [IDX_W-1:0]    idx;
  logic [STATUS_W-1:0] status_next;
  logic                rd_ok;

  always_comb begin
    ctrl_raw    = '0;
    idx         = pos_w;
    status_next = ST_DONE;
    fill_next   = fill_count;
    rd_ok       = 1'b0;
    unique case (operation)
      OP_READ_AT: begin
        rd_ok = (pos_w < fill_w);
      end
      OP_READ_FRONT: begin
        idx   = '0;
        rd_ok = !empty;
      end
      OP_READ_BACK: begin
        idx   = fill_w - IDX_W'(1);
        rd_ok = !empty;
      end
      OP_APPEND: begin
        idx = fill_w;
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctrl_raw.ins = 1'b1;
          fill_next    = fill_count + CNT_W'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_next = ST_RANGE;
        end else begin
          fill_next = fill_count - CNT_W'(1);
        end
      end
      OP_INSERT: begin
        // index past the end appends
        idx = (pos_w > fill_w) ? fill_w : pos_w;
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctrl_raw.ins = 1'b1;
          fill_next    = fill_count + CNT_W'(1);
        end
      end
      OP_ERASE: begin
        if (pos_w >= fill_w) begin
          status_next = ST_RANGE;
        end else begin
          ctrl_raw.del = 1'b1;
          fill_next    = fill_count - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        fill_next = '0;
      end
      default: begin
        fill_next = fill_count;
      end
    endcase
    // read: the addressed cell drives its word, or a missing entry is flagged
    if ((operation == OP_READ_AT) || (operation == OP_READ_FRONT) ||
        (operation == OP_READ_BACK)) begin
      if (rd_ok) begin
        ctrl_raw.rd = 1'b1;
      end else begin
        status_next = ST_RANGE;
      end
    end
  end

  // cells only move on an accepted transaction
  assign ctrl = req_accept ? ctrl_raw : '0;

  // cell chain
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] rd_part   [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_in;
    logic [DATA_WIDTH-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = elem;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_in = cell_data[i];
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end
    olie_cell #(
      .INDEX      (i),
      .IDX_W      (IDX_W),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (idx),
      .elem       (elem),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[i]),
      .rd_data    (rd_part[i])
    );
  end

  // read bus: only the addressed cell drives nonzero
  logic [DATA_WIDTH-1:0] rd_word;
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | rd_part[i];
    end
  end

  logic [DATA_WIDTH+ELEM_W-1:0] rd_ext;
  logic [CNT_W+COUNT_W-1:0]     cnt_ext;
  assign rd_ext  = {{ELEM_W{1'b0}}, rd_word};
  assign cnt_ext = {{COUNT_W{1'b0}}, fill_next};

  // length count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (req_accept) begin
      fill_count <= fill_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req_accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      read_data  <= rd_ext[ELEM_W-1:0];
      read_valid <= ctrl_raw.rd;
      status     <= status_next;
      count      <= cnt_ext[COUNT_W-1:0];
      is_empty   <= (fill_next == '0);
    end
  end

  // checks
  `ASSERT_RST(a_len_bound, clk, rst, fill_count <= FULL_CNT)
  `ASSERT_RST(a_ins_grows, clk, rst, ctrl.ins |=> fill_count == $past(fill_count) + CNT_W'(1))
  `ASSERT_RST(a_del_shrinks, clk, rst, ctrl.del |=> fill_count == $past(fill_count) - CNT_W'(1))
  `ASSERT_RST(a_read_done, clk, rst, (rsp_valid && read_valid) |-> status == ST_DONE)
  `ASSERT_ALWAYS(a_rst_idle, clk, rst |=> !rsp_valid && fill_count == '0)

endmodule
